[rtl/vrrq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vrrq_pkg
// Shared constants and codes of the variable record ring queue.
// ----------------------------------------------------------------------------
package vrrq_pkg;

  // default sizes
  localparam int CAPACITY     = 4096;
  localparam int HEADER_BYTES = 2;

  // request codes
  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;
  localparam logic [1:0] OP_POP     = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;
  localparam logic [1:0] ST_SEQ_ERR = 2'd3;

endpackage
`default_nettype wire

[rtl/vrrq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vrrq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vrrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/variable_record_ring_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// variable_record_ring_queue
// Byte ring of length-prefixed records with batch reserve and byte pop.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// in      | in_valid / in_ready | opcode, request_value, data_in
// out     | out_valid/out_ready | status, data_out, last_of_batch, batch_records,
//         |                     | batch_bytes, used_bytes, front_length
//
// one request at a time through a sequencer around a single byte RAM.
// payload byte and error requests go through the front header read and the
// output stage; begin first writes HEADER_BYTES header bytes, pop first reads
// one byte, and reserve first walks whole records (header reads on the RAM port).
// a new request is taken while a finished result waits at the output register.
// synchronous reset clears pointers and counts; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module variable_record_ring_queue #(
  parameter int CAPACITY     = vrrq_pkg::CAPACITY,
  parameter int HEADER_BYTES = vrrq_pkg::HEADER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] request_value,
  input  wire logic [7:0]  data_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       data_out,
  output logic             last_of_batch,
  output logic [12:0]      batch_records,
  output logic [12:0]      batch_bytes,
  output logic [12:0]      used_bytes,
  output logic [15:0]      front_length
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = ((CW > 17) ? CW : 17) + 1;
  localparam int XW  = (CW > 13) ? CW : 13;
  localparam int HCW = $clog2(HEADER_BYTES + 1);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_HDR_WR    = 11'b000_0000_0010,
    S_POP_A     = 11'b000_0000_0100,
    S_POP_B     = 11'b000_0000_1000,
    S_WALK_CHK  = 11'b000_0001_0000,
    S_WALK_EVAL = 11'b000_0010_0000,
    S_HRD_A     = 11'b000_0100_0000,
    S_HRD_B     = 11'b000_1000_0000,
    S_HRD_C     = 11'b001_0000_0000,
    S_FLEN      = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  state_t state;

  // control state
  logic [PW-1:0]  front;
  logic [PW-1:0]  wp;
  logic [CW-1:0]  occ;
  logic [15:0]    pl;
  logic [CW-1:0]  resv;

  // per request working registers
  logic [1:0]     op_q;
  logic [15:0]    req_q;
  logic [HCW-1:0] hcnt;
  logic [CW-1:0]  rd;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  hoff;
  logic           walk_mode;
  logic           flen_hit;
  logic [15:0]    hdr_len;
  logic [1:0]     st_r;
  logic [7:0]     dout_r;
  logic           last_r;

  logic           acc;
  logic           ram_we;
  logic [PW-1:0]  ram_raddr;
  logic [7:0]     ram_wdata;
  logic [7:0]     ram_rdata;
  logic [7:0]     hdr_byte;
  logic [SW-1:0]  tot;
  logic [XW-1:0]  occ_x;
  logic [XW-1:0]  rd_x;
  logic [XW-1:0]  cnt_x;

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] pos,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(pos) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(CAPACITY)) begin
      sum = sum - (CW + 1)'(CAPACITY);
    end
    return PW'(sum);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  // header byte for the current write slot
  always_comb begin
    if (hcnt == HCW'(0)) begin
      hdr_byte = req_q[7:0];
    end else if (hcnt == HCW'(1)) begin
      hdr_byte = req_q[15:8];
    end else begin
      hdr_byte = 8'h00;
    end
  end

  // RAM port selection
  always_comb begin
    ram_we    = (state == S_HDR_WR) || (acc && opcode == vrrq_pkg::OP_PAYLOAD && pl != 16'd0);
    ram_wdata = (state == S_HDR_WR) ? hdr_byte : data_in;
    unique case (state)
      S_HRD_A: ram_raddr = ring_add(front, hoff);
      S_HRD_B: ram_raddr = ring_add(front, CW'(hoff + CW'(1)));
      default: ram_raddr = front;
    endcase
  end

  assign tot = SW'(HEADER_BYTES) + SW'(hdr_len);

  vrrq_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      wp        <= '0;
      occ       <= '0;
      pl        <= '0;
      resv      <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            op_q   <= opcode;
            req_q  <= request_value;
            st_r   <= vrrq_pkg::ST_OK;
            dout_r <= 8'h00;
            last_r <= 1'b0;
            rd     <= '0;
            cnt    <= '0;
            hcnt   <= '0;
            state  <= S_FLEN;
            case (opcode)
              vrrq_pkg::OP_BEGIN: begin
                if (pl != 16'd0) begin
                  st_r <= vrrq_pkg::ST_SEQ_ERR;
                end else if ((HEADER_BYTES < 2 && request_value > 16'd255) ||
                             (SW'(HEADER_BYTES) + SW'(request_value) >
                              SW'(CAPACITY) - SW'(occ))) begin
                  st_r <= vrrq_pkg::ST_NO_ROOM;
                end else begin
                  state <= S_HDR_WR;
                end
              end
              vrrq_pkg::OP_PAYLOAD: begin
                if (pl == 16'd0) begin
                  st_r <= vrrq_pkg::ST_SEQ_ERR;
                end else begin
                  wp  <= ring_add(wp, CW'(1));
                  occ <= occ + CW'(1);
                  pl  <= pl - 16'd1;
                end
              end
              vrrq_pkg::OP_RESERVE: begin
                if (resv != '0) begin
                  st_r <= vrrq_pkg::ST_SEQ_ERR;
                end else begin
                  state <= S_WALK_CHK;
                end
              end
              default: begin
                if (resv == '0 || occ == '0) begin
                  st_r <= vrrq_pkg::ST_NOTHING;
                end else begin
                  state <= S_POP_A;
                end
              end
            endcase
          end
        end
        // header bytes, one per cycle
        S_HDR_WR: begin
          wp   <= ring_add(wp, CW'(1));
          occ  <= occ + CW'(1);
          hcnt <= hcnt + HCW'(1);
          if (hcnt == HCW'(HEADER_BYTES - 1)) begin
            pl    <= req_q;
            state <= S_FLEN;
          end
        end
        S_POP_A: begin
          state <= S_POP_B;
        end
        S_POP_B: begin
          dout_r <= ram_rdata;
          front  <= ring_add(front, CW'(1));
          occ    <= occ - CW'(1);
          resv   <= resv - CW'(1);
          last_r <= (resv == CW'(1));
          state  <= S_FLEN;
        end
        // walk loop over whole records from the front
        S_WALK_CHK: begin
          if (SW'(rd) < SW'(req_q) && rd < occ &&
              SW'(occ - rd) >= SW'(HEADER_BYTES)) begin
            hoff      <= rd;
            walk_mode <= 1'b1;
            state     <= S_HRD_A;
          end else begin
            if (cnt == '0) begin
              st_r <= vrrq_pkg::ST_NOTHING;
            end else begin
              resv <= rd;
            end
            state <= S_FLEN;
          end
        end
        S_WALK_EVAL: begin
          if (SW'(rd) + tot > SW'(req_q) || SW'(rd) + tot > SW'(occ)) begin
            if (cnt == '0) begin
              st_r <= vrrq_pkg::ST_NOTHING;
            end else begin
              resv <= rd;
            end
            state <= S_FLEN;
          end else begin
            rd    <= rd + CW'(tot);
            cnt   <= cnt + CW'(1);
            state <= S_WALK_CHK;
          end
        end
        // header read, low byte then, unless HEADER_BYTES is 1, high byte
        S_HRD_A: begin
          state <= S_HRD_B;
        end
        S_HRD_B: begin
          hdr_len <= {8'h00, ram_rdata};
          if (HEADER_BYTES == 1) begin
            state <= walk_mode ? S_WALK_EVAL : S_DONE;
          end else begin
            state <= S_HRD_C;
          end
        end
        S_HRD_C: begin
          hdr_len[15:8] <= ram_rdata;
          state         <= walk_mode ? S_WALK_EVAL : S_DONE;
        end
        // first header not yet reserved
        S_FLEN: begin
          walk_mode <= 1'b0;
          if (occ >= resv && SW'(occ - resv) >= SW'(HEADER_BYTES)) begin
            flen_hit <= 1'b1;
            hoff     <= resv;
            state    <= S_HRD_A;
          end else begin
            flen_hit <= 1'b0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= st_r;
            data_out      <= dout_r;
            last_of_batch <= last_r;
            batch_records <= (op_q == vrrq_pkg::OP_RESERVE && st_r == vrrq_pkg::ST_OK) ?
                             cnt_x[12:0] : 13'd0;
            batch_bytes   <= (op_q == vrrq_pkg::OP_RESERVE && st_r == vrrq_pkg::ST_OK) ?
                             rd_x[12:0] : 13'd0;
            used_bytes    <= occ_x[12:0];
            front_length  <= flen_hit ? hdr_len : 16'd0;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign occ_x = XW'(occ);
  assign rd_x  = XW'(rd);
  assign cnt_x = XW'(cnt);

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CW'(CAPACITY))
    else $error("occupied count above capacity");
  a_resv_bound: assert property (@(posedge clk) disable iff (rst) resv <= occ)
    else $error("reserved bytes above occupied bytes");
  a_ring: assert property (@(posedge clk) disable iff (rst) wp == ring_add(front, occ))
    else $error("write pointer out of step with front and count");

endmodule
`default_nettype wire
